@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ hw/rtl/pr9s_pkg.sv @@
// Types, constants and helpers of the pulse-run nine-bit serial decoder.
`timescale 1ns / 1ps
`default_nettype none
package pr9s_pkg;

  localparam int unsigned TICK_W     = 15;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned RUN_W      = 18;   // signed run time in us
  localparam int unsigned FRAME_BITS = 11;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned WORD_W     = 9;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd104;
  localparam logic [POS_W-1:0]    POS_LAST     = 4'd10;
  localparam logic [POS_W-1:0]    POS_FULL     = 4'd11;

  typedef logic signed [RUN_W-1:0] run_t;
  typedef logic [PERIOD_W-1:0]     period_t;
  typedef logic [TICK_W-1:0]       ticks_t;
  typedef logic [FRAME_BITS-1:0]   frame_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [WORD_W-1:0]       word_t;

  // Result of one pass through the shared compare/subtract unit.
  typedef struct packed {
    logic gt_half;   // run time left exceeds half a bit period
    run_t diff;      // run time left minus one bit period
  } step_t;

  // ticks * 2.5, floored: (5 * ticks) >> 1
  function automatic run_t scale_us(input ticks_t ticks);
    logic [17:0] x5;
    x5 = {3'b000, ticks} + {1'b0, ticks, 2'b00};
    return run_t'({1'b0, x5[17:1]});
  endfunction

  // Frame bits 1..9.
  function automatic word_t frame_word(input frame_t f);
    return f[WORD_W:1];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pulse_runs_to_nine_bit_serial_decoder_top.sv @@
// Top level of the pulse-run nine-bit serial decoder: sequencer and state.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata: low_ticks, high_ticks
//  out_    | out | out_tvalid/out_tready| out_tdata: word
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data: bit_period_us
//
// Sequence: after a beat is taken in_tready stays low while the low run, then
//   the high run are counted bit by bit and the end state is handled, so no
//   new beat is taken before the last one is through. Each counted bit is one
//   pass of the shared compare/subtract unit.
// Reset: rst_n low clears the frame state and sets bit_period_us to 104.
// Stalls: a waiting result does not block a new beat; only the final cycle
//   of an item that yields a word waits for the output register to free up.
// cfg_ready is always high; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pulse_runs_to_nine_bit_serial_decoder_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,    // [14:0] low_ticks, [29:15] high_ticks, [31:30] zero
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata,  // [8:0] word, [15:9] zero
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [7:0]  cfg_data     // [7:0] bit_period_us
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a beat
  localparam logic [1:0] ST_LOW  = 2'd1;  // counting zero bits
  localparam logic [1:0] ST_HIGH = 2'd2;  // counting one bits
  localparam logic [1:0] ST_END  = 2'd3;  // end-of-frame handling, result out

  logic [1:0]          state_r, state_nxt;
  pr9s_pkg::period_t   period_r, period_nxt;
  pr9s_pkg::run_t      t_r, t_nxt;           // run time left, us
  pr9s_pkg::ticks_t    high_r, high_nxt;     // high run of current beat
  pr9s_pkg::pos_t      pos_r, pos_nxt;
  pr9s_pkg::frame_t    shift_r, shift_nxt;
  logic                err_r, err_nxt;
  logic                pend_r, pend_nxt;     // word completed in high run
  pr9s_pkg::word_t     pend_word_r, pend_word_nxt;
  logic                out_valid_r, out_valid_nxt;
  pr9s_pkg::word_t     out_word_r, out_word_nxt;

  pr9s_pkg::step_t     step;
  pr9s_pkg::pos_t      pos_inc;
  pr9s_pkg::frame_t    shift_set;
  pr9s_pkg::frame_t    fill_mask;
  logic [pr9s_pkg::FRAME_BITS:0] low_bits;
  logic                end_zero;
  logic                produce;
  logic                out_busy;

  pr9s_step_unit u_step (
    .t      (t_r),
    .period (period_r),
    .step   (step)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - pr9s_pkg::WORD_W){1'b0}}, out_word_r};

  assign pos_inc   = pos_r + 4'd1;
  assign shift_set = shift_r | (pr9s_pkg::frame_t'(1) << pos_r);
  // positions at and above pos_r: idle ones at the end of a frame
  assign low_bits  = (12'd1 << pos_r) - 12'd1;
  assign fill_mask = ~low_bits[pr9s_pkg::FRAME_BITS-1:0];
  assign end_zero  = (high_r == '0);
  assign produce   = end_zero ? !err_r : pend_r;
  assign out_busy  = out_valid_r && !out_tready;

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    t_nxt         = t_r;
    high_nxt      = high_r;
    pos_nxt       = pos_r;
    shift_nxt     = shift_r;
    err_nxt       = err_r;
    pend_nxt      = pend_r;
    pend_word_nxt = pend_word_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_valid) begin
      period_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          t_nxt     = pr9s_pkg::scale_us(in_tdata[14:0]);
          high_nxt  = in_tdata[29:15];
          state_nxt = ST_LOW;
        end
      end
      ST_LOW: begin
        if (step.gt_half && !err_r) begin
          t_nxt   = step.diff;
          pos_nxt = pos_inc;
          if (pos_r == pr9s_pkg::POS_LAST) begin
            // low run overran the frame
            err_nxt   = 1'b1;
            t_nxt     = pr9s_pkg::scale_us(high_r);
            state_nxt = ST_HIGH;
          end
        end else begin
          t_nxt     = pr9s_pkg::scale_us(high_r);
          state_nxt = ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (step.gt_half && !err_r) begin
          t_nxt     = step.diff;
          pos_nxt   = pos_inc;
          shift_nxt = shift_set;
          if (pos_r == pr9s_pkg::POS_LAST) begin
            // frame full: rest of the high run is dropped
            pend_nxt      = 1'b1;
            pend_word_nxt = pr9s_pkg::frame_word(shift_set);
            pos_nxt       = '0;
            shift_nxt     = '0;
            state_nxt     = ST_END;
          end
        end else begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (!(produce && out_busy)) begin
          if (produce) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = end_zero ? pr9s_pkg::frame_word(shift_r | fill_mask)
                                     : pend_word_r;
          end
          if (end_zero) begin
            pos_nxt   = '0;
            shift_nxt = '0;
            err_nxt   = 1'b0;
          end
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= pr9s_pkg::PERIOD_RESET;
      pos_r       <= '0;
      shift_r     <= '0;
      err_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      pos_r       <= pos_nxt;
      shift_r     <= shift_nxt;
      err_r       <= err_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    high_r      <= high_nxt;
    pend_word_r <= pend_word_nxt;
    out_word_r  <= out_word_nxt;
  end

  `ASSERT_NEVER(a_pos_range, clk, rst_n, pos_r > pr9s_pkg::POS_FULL, "bit position past frame end")
  `ASSERT_CLK(a_err_pos, clk, rst_n, err_r |-> (pos_r == pr9s_pkg::POS_FULL), "framing error without full count")
  `ASSERT_CLK(a_pend_end, clk, rst_n, pend_r |-> (state_r == ST_END), "pending word outside end state")
  `ASSERT_CLK(a_out_hold, clk, rst_n, (state_r == ST_END && produce && out_busy) |=> (state_r == ST_END), "end state left while output busy")

endmodule
`default_nettype wire

@@ hw/rtl/pr9s_step_unit.sv @@
// Shared compare and subtract unit: one bit period per pass.
`timescale 1ns / 1ps
`default_nettype none
module pr9s_step_unit (
  input  wire pr9s_pkg::run_t    t,
  input  wire pr9s_pkg::period_t period,
  output pr9s_pkg::step_t        step
);

  pr9s_pkg::run_t period_s;
  pr9s_pkg::run_t half_s;

  assign period_s = pr9s_pkg::run_t'({{(pr9s_pkg::RUN_W - pr9s_pkg::PERIOD_W){1'b0}}, period});
  assign half_s   = pr9s_pkg::run_t'({{(pr9s_pkg::RUN_W - pr9s_pkg::PERIOD_W + 1){1'b0}},
                                      period[pr9s_pkg::PERIOD_W-1:1]});

  assign step.gt_half = (t > half_s);
  assign step.diff    = t - period_s;

endmodule
`default_nettype wire
